FILE: sv/simd_md_pkg.sv
`timescale 1ns / 1ps
package simd_md_pkg;

  typedef enum logic [3:0] {
    K_DIV     = 4'd0,
    K_DIVU    = 4'd1,
    K_MULT    = 4'd2,
    K_MULTU   = 4'd3,
    K_PDIVBW  = 4'd4,
    K_PDIVUW  = 4'd5,
    K_PDIVW   = 4'd6,
    K_PMULTH  = 4'd7,
    K_PMULTUW = 4'd8,
    K_PMULTW  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FIX,
    ST_DONE
  } state_t;

  localparam int unsigned WordW = 32;
  localparam int unsigned Lanes = 4;
  localparam int unsigned CntW  = $clog2(WordW + 1);

  function automatic logic [63:0] sext32(input logic [31:0] x);
    sext32 = {{32{x[31]}}, x};
  endfunction

endpackage

FILE: sv/simd_md_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: one subtract-compare unit per lane, one quotient
// bit per cycle. Operands are magnitudes; the caller fixes signs.
module simd_md_div (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  import simd_md_pkg::*;

  logic [31:0] q_r, r_r, d_r;
  logic [32:0] sh;
  logic [32:0] diff;

  always_comb begin
    sh   = {r_r, q_r[31]};
    diff = sh - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      r_r <= '0;
      d_r <= den;
    end else begin
      if (!diff[32]) begin
        r_r <= diff[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= sh[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign quo = q_r;
  assign rem = r_r;
endmodule

FILE: sv/simd_integer_mult_div_unit_core.sv
`timescale 1ns / 1ps
// Multiply: states LOAD, RUN (product register), FIX, then DONE with the result valid.
// Divide: load, 32 iterations of the per-lane radix-2 divider, sign fix.
// One operation at a time; in_ready is high only when idle. A new item is accepted only
// after the result is taken. Synchronous active-low reset clears control and LO/HI to zero.
module simd_integer_mult_div_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_kind,
  input  logic [63:0] in_rs_low,
  input  logic [63:0] in_rs_high,
  input  logic [63:0] in_rt_low,
  input  logic [63:0] in_rt_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_rd_low,
  output logic [63:0] out_rd_high,
  output logic [1:0]  out_rd_mask,
  output logic [63:0] out_lo_low,
  output logic [63:0] out_lo_high,
  output logic [63:0] out_hi_low,
  output logic [63:0] out_hi_high
);
  import simd_md_pkg::*;

  state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r;
  logic [3:0]  kind_r;
  logic [63:0] rsl_r, rsh_r, rtl_r, rth_r;
  logic [127:0] rs_all, rt_all;
  logic [63:0] lo_r [2];
  logic [63:0] hi_r [2];
  logic [63:0] rd_r [2];
  logic [1:0]  mask_r;

  // Per-lane operand setup.
  logic [31:0] an [Lanes];
  logic [31:0] bn [Lanes];
  logic        na [Lanes];
  logic        nb [Lanes];
  logic        zb [Lanes];
  logic [31:0] ua [Lanes];
  logic [31:0] ub [Lanes];
  logic        neg_q_r [Lanes];
  logic        neg_r_r [Lanes];
  logic        zero_r  [Lanes];
  logic [31:0] quo [Lanes];
  logic [31:0] rem [Lanes];
  logic [31:0] fq [Lanes];
  logic [31:0] fr [Lanes];
  logic        sgn;
  logic        is_div;

  assign is_div = (kind_r == K_DIV) || (kind_r == K_DIVU) || (kind_r == K_PDIVBW) ||
                  (kind_r == K_PDIVUW) || (kind_r == K_PDIVW);
  assign sgn = (kind_r == K_DIV) || (kind_r == K_PDIVBW) || (kind_r == K_PDIVW);
  assign rs_all = {rsh_r, rsl_r};
  assign rt_all = {rth_r, rtl_r};

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      an[i] = rs_all[32*i +: 32];
      bn[i] = rt_all[32*i +: 32];
      if (kind_r == K_PDIVBW) begin
        bn[i] = {{16{rtl_r[15]}}, rtl_r[15:0]};
      end else if (kind_r == K_PDIVUW || kind_r == K_PDIVW) begin
        an[i] = (i < 2) ? rsl_r[31:0] : rsh_r[31:0];
        bn[i] = (i < 2) ? rtl_r[31:0] : rth_r[31:0];
      end
      na[i] = sgn & an[i][31];
      nb[i] = sgn & bn[i][31];
      zb[i] = (bn[i] == '0);
      ua[i] = na[i] ? (32'd0 - an[i]) : an[i];
      ub[i] = nb[i] ? (32'd0 - bn[i]) : bn[i];
      fq[i] = neg_q_r[i] ? (32'd0 - quo[i]) : quo[i];
      fr[i] = neg_r_r[i] ? (32'd0 - rem[i]) : rem[i];
      if (zero_r[i]) begin
        fq[i] = '0;
        fr[i] = '0;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < Lanes; g++) begin : g_lane
      simd_md_div u_div (
        .clk   (clk),
        .start (state_r == ST_LOAD),
        .num   (ua[g]),
        .den   (ub[g]),
        .quo   (quo[g]),
        .rem   (rem[g])
      );
    end
  endgenerate

  // Multiplies: two 33x33 signed multipliers, result registered; eight 16x16 signed halfword products.
  logic signed [32:0] ma [2];
  logic signed [32:0] mb [2];
  logic [63:0]        pr_r [2];
  logic signed [65:0] pw [2];
  logic [31:0]        hv [8];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [63:0] s, t;
      s = (i == 0) ? rsl_r : rsh_r;
      t = (i == 0) ? rtl_r : rth_r;
      if (kind_r == K_MULT || kind_r == K_PMULTW) begin
        ma[i] = {s[31], s[31:0]};
        mb[i] = {t[31], t[31:0]};
      end else begin
        ma[i] = {1'b0, s[31:0]};
        mb[i] = {1'b0, t[31:0]};
      end
      pw[i] = ma[i] * mb[i];
    end
    for (int j = 0; j < 8; j++) begin
      logic [63:0] s, t;
      logic signed [31:0] px;
      s = (j < 4) ? rsl_r : rsh_r;
      t = (j < 4) ? rtl_r : rth_r;
      px = $signed(s[16*(j%4) +: 16]) * $signed(t[16*(j%4) +: 16]);
      hv[j] = px;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_RUN;
      ST_RUN: begin
        if (!is_div || cnt_r == CntW'(WordW - 1)) state_nxt = ST_FIX;
      end
      ST_FIX:  state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      lo_r[0] <= '0; lo_r[1] <= '0;
      hi_r[0] <= '0; hi_r[1] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_valid) begin
        kind_r <= in_kind;
        rsl_r  <= in_rs_low;
        rsh_r  <= in_rs_high;
        rtl_r  <= in_rt_low;
        rth_r  <= in_rt_high;
      end
      if (state_r == ST_LOAD) begin
        cnt_r <= '0;
        for (int i = 0; i < Lanes; i++) begin
          neg_q_r[i] <= na[i] ^ nb[i];
          neg_r_r[i] <= na[i];
          zero_r[i]  <= zb[i];
        end
      end
      if (state_r == ST_RUN) begin
        cnt_r <= cnt_r + 1'b1;
        pr_r[0] <= pw[0][63:0];
        pr_r[1] <= pw[1][63:0];
      end
      if (state_r == ST_FIX) begin
        unique case (kind_r)
          K_DIV, K_DIVU: begin
            rd_r[0] <= '0;
            rd_r[1] <= '0;
            mask_r  <= 2'd0;
            if (!zero_r[0]) begin
              lo_r[0] <= sext32(fq[0]);
              hi_r[0] <= sext32(fr[0]);
            end
          end
          K_MULT, K_MULTU: begin
            rd_r[0] <= sext32(pr_r[0][31:0]);
            rd_r[1] <= '0;
            lo_r[0] <= sext32(pr_r[0][31:0]);
            hi_r[0] <= sext32(pr_r[0][63:32]);
            mask_r  <= 2'd1;
          end
          K_PDIVBW: begin
            rd_r[0] <= '0;
            rd_r[1] <= '0;
            mask_r  <= 2'd0;
            lo_r[0] <= {fq[1], fq[0]};
            lo_r[1] <= {fq[3], fq[2]};
            hi_r[0] <= {fr[1], fr[0]};
            hi_r[1] <= {fr[3], fr[2]};
          end
          K_PDIVUW, K_PDIVW: begin
            rd_r[0] <= '0;
            rd_r[1] <= '0;
            mask_r  <= 2'd0;
            lo_r[0] <= sext32(fq[0]);
            lo_r[1] <= sext32(fq[2]);
            hi_r[0] <= sext32(fr[0]);
            hi_r[1] <= sext32(fr[2]);
          end
          K_PMULTH: begin
            rd_r[0] <= {hv[2], hv[0]};
            rd_r[1] <= {hv[6], hv[4]};
            lo_r[0] <= {hv[1], hv[0]};
            lo_r[1] <= {hv[5], hv[4]};
            hi_r[0] <= {hv[3], hv[2]};
            hi_r[1] <= {hv[7], hv[6]};
            mask_r  <= 2'd3;
          end
          K_PMULTUW, K_PMULTW: begin
            rd_r[0] <= pr_r[0];
            rd_r[1] <= pr_r[1];
            lo_r[0] <= sext32(pr_r[0][31:0]);
            lo_r[1] <= sext32(pr_r[1][31:0]);
            hi_r[0] <= sext32(pr_r[0][63:32]);
            hi_r[1] <= sext32(pr_r[1][63:32]);
            mask_r  <= 2'd3;
          end
          default: begin
            rd_r[0] <= '0;
            rd_r[1] <= '0;
            mask_r  <= 2'd0;
          end
        endcase
      end
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_DONE);
  assign out_rd_low  = rd_r[0];
  assign out_rd_high = rd_r[1];
  assign out_rd_mask = mask_r;
  assign out_lo_low  = lo_r[0];
  assign out_lo_high = lo_r[1];
  assign out_hi_low  = hi_r[0];
  assign out_hi_high = hi_r[1];
endmodule
